### rtl/core/window_extremum_keypoint_detect_defines.svh
// Assertion macros for the keypoint detector; empty bodies when SYNTH is defined.
`ifndef WINDOW_EXTREMUM_KEYPOINT_DETECT_DEFINES_SVH
`define WINDOW_EXTREMUM_KEYPOINT_DETECT_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define WEKD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// condition must never be seen outside reset
`define WEKD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define WEKD_ASSERT(lbl, clk, rst, prop)
`define WEKD_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### rtl/core/wekd_pkg.sv
// Shared constants, types and helpers of the window extremum keypoint detector.
package wekd_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int WINDOW_SIZE_DEF = 7;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int THR_W      = 8;
  localparam int COORD_W    = 10;
  localparam int SIZE_W     = 13;
  localparam int FIFO_DEPTH = 8;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd512;
  localparam logic [THR_W-1:0] THR_RST    = 8'd11;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CONTRAST     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               keypoint_flag;
    logic [COORD_W-1:0] centre_row;
    logic [COORD_W-1:0] centre_col;
  } result_t;

  // saturate a programmed size into [lo, hi]
  function automatic logic [SIZE_W-1:0] sat_size(input logic [CFG_W-1:0]  v,
                                                 input logic [SIZE_W-1:0] lo,
                                                 input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] x;
    x = SIZE_W'(v);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

endpackage

### rtl/core/wekd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wekd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/window_extremum_keypoint_detect.sv
// Window extremum keypoint detector: line store, 7x7 window, min/max test, result queue.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_stall    | pixel
//  out     | out_valid / out_stall  | keypoint_flag, centre_row, centre_col
//
// One pixel per cycle while in_stall is low; out_valid rises once the result has passed v1, v2 and v3 into the queue.
// The line store is one RAM word per column (all buffered rows side by side): read at
// accept, written back the next cycle, so each pixel costs one read and one write.
// Reset clears counters, pipeline and result queue; line store contents are left as is.
// in_stall rises only when FIFO_DEPTH results are outstanding (out side stalled).
`include "window_extremum_keypoint_detect_defines.svh"

module window_extremum_keypoint_detect #(
  parameter int MAX_WIDTH   = wekd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = wekd_pkg::MAX_HEIGHT_DEF,
  parameter int WINDOW_SIZE = wekd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [wekd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wekd_pkg::PIX_W-1:0]   pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         keypoint_flag,
  output logic [wekd_pkg::COORD_W-1:0] centre_row,
  output logic [wekd_pkg::COORD_W-1:0] centre_col
);

  localparam int PW    = wekd_pkg::PIX_W;
  localparam int SW    = wekd_pkg::SIZE_W;
  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int LINES = WINDOW_SIZE - 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int LW    = LINES * PW;
  localparam int FD    = wekd_pkg::FIFO_DEPTH;
  localparam int FAW   = $clog2(FD);
  localparam int FCW   = $clog2(FD + 1);

  // configuration
  logic [wekd_pkg::CFG_W-1:0] image_width;
  logic [wekd_pkg::CFG_W-1:0] image_height;
  logic [wekd_pkg::THR_W-1:0] contrast_threshold;
  logic [SW-1:0]              w_sat;
  logic [SW-1:0]              h_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= wekd_pkg::WIDTH_RST;
      image_height       <= wekd_pkg::HEIGHT_RST;
      contrast_threshold <= wekd_pkg::THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wekd_pkg::cfg_reg_t'(cfg_index))
        wekd_pkg::REG_IMAGE_WIDTH:  image_width        <= cfg_data;
        wekd_pkg::REG_IMAGE_HEIGHT: image_height       <= cfg_data;
        wekd_pkg::REG_CONTRAST:     contrast_threshold <= cfg_data[wekd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_sat = wekd_pkg::sat_size(image_width, SW'(WINDOW_SIZE), SW'(MAX_WIDTH));
  assign h_sat = wekd_pkg::sat_size(image_height, SW'(WINDOW_SIZE), SW'(MAX_HEIGHT));

  // raster position (stage 0)
  logic [CW-1:0] col_count, col_count_next, col_eff;
  logic [RW-1:0] row_count, row_count_next, row_eff;
  logic [SW-1:0] col_inc, row_inc;
  logic          in_accept;
  logic          produce;
  logic [FCW-1:0] pending;

  assign in_stall  = (pending >= FCW'(FD));
  assign in_accept = in_valid && !in_stall;

  // a size rewritten below the current position wraps the counter at once
  assign col_eff = (SW'(col_count) >= w_sat) ? '0 : col_count;
  assign row_eff = (SW'(row_count) >= h_sat) ? '0 : row_count;
  assign col_inc = SW'(col_eff) + SW'(1);
  assign row_inc = SW'(row_eff) + SW'(1);
  assign produce = (SW'(row_eff) >= SW'(WINDOW_SIZE - 1)) &&
                   (SW'(col_eff) >= SW'(WINDOW_SIZE - 1));

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (in_accept) begin
      if (col_inc >= w_sat) begin
        col_count_next = '0;
        row_count_next = (row_inc >= h_sat) ? '0 : row_inc[RW-1:0];
      end else begin
        col_count_next = col_inc[CW-1:0];
        row_count_next = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line store
  logic          v1;
  logic          s1_prod;
  logic [PW-1:0] s1_pixel;
  logic [CW-1:0] s1_col;
  logic [wekd_pkg::COORD_W-1:0] s1_row_c, s1_col_c;
  logic [LW-1:0] line_rdata;
  logic [LW-1:0] line_wdata;

  wekd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (v1),
    .waddr (s1_col),
    .wdata (line_wdata),
    .re    (in_accept),
    .raddr (col_eff),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_prod  <= produce;
      s1_pixel <= pixel;
      s1_col   <= col_eff;
      s1_row_c <= wekd_pkg::COORD_W'(SW'(row_eff) - SW'(HALF));
      s1_col_c <= wekd_pkg::COORD_W'(SW'(col_eff) - SW'(HALF));
    end
  end

  // stage 1: new column, write-back, column extremes, window shift
  logic [PW-1:0] column [WINDOW_SIZE];
  logic [PW-1:0] new_min, new_max;

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      column[k] = line_rdata[k*PW +: PW];
    end
    column[LINES] = s1_pixel;
    for (int k = 0; k < LINES; k++) begin
      line_wdata[k*PW +: PW] = column[k+1];
    end
  end

  always_comb begin
    new_min = column[0];
    new_max = column[0];
    for (int k = 1; k < WINDOW_SIZE; k++) begin
      if (column[k] < new_min) new_min = column[k];
      if (column[k] > new_max) new_max = column[k];
    end
  end

  logic [PW-1:0] win_px  [WINDOW_SIZE][WINDOW_SIZE];
  logic [PW-1:0] col_min [WINDOW_SIZE];
  logic [PW-1:0] col_max [WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int r = 0; r < WINDOW_SIZE; r++) begin
        for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
          win_px[r][c] <= win_px[r][c+1];
        end
        win_px[r][WINDOW_SIZE-1] <= column[r];
      end
      for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
        col_min[c] <= col_min[c+1];
        col_max[c] <= col_max[c+1];
      end
      col_min[WINDOW_SIZE-1] <= new_min;
      col_max[WINDOW_SIZE-1] <= new_max;
    end
  end

  logic v2;
  logic [wekd_pkg::COORD_W-1:0] s2_row_c, s2_col_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && s1_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s2_row_c <= s1_row_c;
      s2_col_c <= s1_col_c;
    end
  end

  // stage 2: window extremes from the per-column extremes
  logic [PW-1:0] win_min, win_max;

  always_comb begin
    win_min = col_min[0];
    win_max = col_max[0];
    for (int c = 1; c < WINDOW_SIZE; c++) begin
      if (col_min[c] < win_min) win_min = col_min[c];
      if (col_max[c] > win_max) win_max = col_max[c];
    end
  end

  logic          v3;
  logic [PW-1:0] s3_min, s3_max, s3_ctr;
  logic [wekd_pkg::COORD_W-1:0] s3_row_c, s3_col_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      s3_min   <= win_min;
      s3_max   <= win_max;
      s3_ctr   <= win_px[HALF][HALF];
      s3_row_c <= s2_row_c;
      s3_col_c <= s2_col_c;
    end
  end

  // stage 3: contrast and extremum test
  wekd_pkg::result_t res;
  logic [PW-1:0]     contrast;

  assign contrast = s3_max - s3_min;

  always_comb begin
    res.keypoint_flag = (contrast > contrast_threshold) &&
                        ((s3_ctr == s3_max) || (s3_ctr == s3_min));
    res.centre_row    = s3_row_c;
    res.centre_col    = s3_col_c;
  end

  // result queue; pending counts results from their input beat to their output beat
  wekd_pkg::result_t fifo_mem [FD];
  logic [FAW-1:0]    wr_ptr, rd_ptr;
  logic [FCW-1:0]    fcnt;
  logic              pop;
  logic              take;

  assign out_valid = (fcnt != '0);
  assign pop       = out_valid && !out_stall;
  assign take      = in_accept && produce;

  always_ff @(posedge clk) begin
    if (v3) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fcnt    <= '0;
      pending <= '0;
    end else begin
      if (v3) wr_ptr <= wr_ptr + FAW'(1);
      if (pop) rd_ptr <= rd_ptr + FAW'(1);
      fcnt    <= fcnt + FCW'(v3) - FCW'(pop);
      pending <= pending + FCW'(take) - FCW'(pop);
    end
  end

  assign keypoint_flag = fifo_mem[rd_ptr].keypoint_flag;
  assign centre_row    = fifo_mem[rd_ptr].centre_row;
  assign centre_col    = fifo_mem[rd_ptr].centre_col;

  // checks
  `WEKD_ASSERT_NEVER(a_pending_bound, clk, rst, pending > FCW'(FD))
  `WEKD_ASSERT_NEVER(a_queue_within_credit, clk, rst, fcnt > pending)
  `WEKD_ASSERT_NEVER(a_push_into_full, clk, rst, v3 && (fcnt == FCW'(FD)))
  `WEKD_ASSERT_NEVER(a_line_store_collision, clk, rst, in_accept && v1 && (col_eff == s1_col))

endmodule
